// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the stream pattern masker RTL
// Clocked property checks that report through $error.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset has been released
`define SPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define SPM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/spm_pkg.sv =====
// ---------------------------------------------------------------------------
// spm_pkg
// Types and constants shared by the stream pattern masker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

  // Longest pattern and size of the pending window / result queue
  localparam int unsigned MaxPattern = 8;
  localparam int unsigned ByteW      = 8;
  // Pending byte count, 0 .. MaxPattern-1
  localparam int unsigned CntW       = $clog2(MaxPattern);
  // Pattern length and result count, 0 .. MaxPattern
  localparam int unsigned LenW       = $clog2(MaxPattern + 1);
  localparam int unsigned PatW       = MaxPattern * ByteW;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgLenW    = 4;

  localparam logic [ByteW-1:0] StarByte = 8'd42;

  typedef logic [ByteW-1:0] byte_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternBytes  = 2'd0,
    CfgPatternLength = 2'd1
  } cfg_reg_e;

  // Control from the top level to one queue slot
  typedef struct packed {
    logic load;   // take a fresh result from the step logic
    logic shift;  // take the neighbour's byte, moving one place to the head
  } slot_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/stream_pattern_masker_unit.sv =====
// ---------------------------------------------------------------------------
// stream_pattern_masker_unit
// Replaces each leftmost, non-overlapping occurrence of a configured byte
// pattern in a stream by as many star bytes; other bytes pass unchanged.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Payload                               Transfer when
// s_axis    in   tdata: data_byte, tuser: end_of_input  tvalid & tready
// m_axis    out  tdata: out_byte, tlast: last_of_run    tvalid & tready
// cfg       in   index 0 pattern_bytes, 1 pattern_length valid_i & ready_o
//
// An input transfer is resolved in the cycle it is taken: the window cells
// and the result queue are written at that edge. Results leave the queue
// head one per cycle while m_axis_tready is high; the next input is taken
// while the last result of the previous item is being transferred, giving
// one item per cycle while each item produces at most one result and the
// output does not stall. After a match the input waits until the queue has
// emptied to its last star. Reset clears the pending count and the queue;
// configuration is always accepted, with no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module stream_pattern_masker_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
  input  logic                                s_axis_tuser,  // [0] end_of_input
  // Output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // [7:0] out_byte
  output logic                                m_axis_tlast,  // last_of_run
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spm_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [spm_pkg::PatW-1:0]            cfg_data_i
);

  localparam int unsigned N = spm_pkg::MaxPattern;

  // Configuration registers
  logic [spm_pkg::PatW-1:0]    pattern_q;
  logic [spm_pkg::CfgLenW-1:0] length_q;

  // Pending count and result queue fill
  logic [spm_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [spm_pkg::LenW-1:0] oc_q, oc_d;

  logic in_acc, drain, flush;
  logic [spm_pkg::LenW-1:0] eff_len, n_items, excess_w, res_cnt;
  logic match_ok, match_take, short_win;

  spm_pkg::byte_t win_byte  [N];
  spm_pkg::byte_t appended  [N];
  spm_pkg::byte_t cand_byte [N];
  spm_pkg::byte_t next_win  [N];
  spm_pkg::byte_t res_byte  [N];
  spm_pkg::byte_t slot_byte [N];
  logic [N-1:0]   cell_eq;
  spm_pkg::slot_ctrl_t slot_ctrl;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= spm_pkg::CfgLenW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spm_pkg::CfgPatternBytes:  pattern_q <= cfg_data_i;
        spm_pkg::CfgPatternLength: length_q  <= cfg_data_i[spm_pkg::CfgLenW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to 1 .. MaxPattern
  always_comb begin
    priority if (length_q == '0) begin
      eff_len = spm_pkg::LenW'(1);
    end else if (length_q > spm_pkg::CfgLenW'(N)) begin
      eff_len = spm_pkg::LenW'(N);
    end else begin
      eff_len = spm_pkg::LenW'(length_q);
    end
  end

  // Handshakes: take input while the queue is empty or passing its last result
  assign drain         = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = (oc_q == '0) | ((oc_q == spm_pkg::LenW'(1)) & m_axis_tready);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign flush         = s_axis_tuser;

  // Window with the new byte appended after the pending ones
  always_comb begin
    for (int i = 0; i < N; i++) begin
      appended[i] = (spm_pkg::CntW'(i) < cnt_q) ? win_byte[i] : s_axis_tdata;
    end
  end

  // Bytes beyond the length leave first, then the rest is matched
  assign n_items  = spm_pkg::LenW'(cnt_q) + spm_pkg::LenW'(1);
  assign excess_w = (n_items > eff_len) ? (n_items - eff_len) : '0;
  assign short_win = (n_items < eff_len);

  // Align the candidate window with the pattern
  always_comb begin
    logic [spm_pkg::LenW-1:0] idx;
    for (int i = 0; i < N; i++) begin
      idx = excess_w + spm_pkg::LenW'(i);
      cand_byte[i] = appended[idx[spm_pkg::CntW-1:0]];
    end
  end

  // Combine the cell compares over the used pattern length
  always_comb begin
    match_ok = !short_win;
    for (int i = 0; i < N; i++) begin
      if ((spm_pkg::LenW'(i) < eff_len) && !cell_eq[i]) begin
        match_ok = 1'b0;
      end
    end
  end

  assign match_take = !flush && match_ok;

  // Number of results this transfer causes
  always_comb begin
    priority if (flush) begin
      res_cnt = spm_pkg::LenW'(cnt_q);
    end else if (short_win) begin
      res_cnt = '0;
    end else if (match_ok) begin
      res_cnt = n_items;
    end else begin
      res_cnt = excess_w + spm_pkg::LenW'(1);
    end
  end

  // Results: the oldest bytes, with stars in place of the matched window
  always_comb begin
    for (int j = 0; j < N; j++) begin
      res_byte[j] = (match_take && (spm_pkg::LenW'(j) >= excess_w)) ?
                    spm_pkg::StarByte : appended[j];
    end
  end

  // Remaining window: drop the emitted bytes from the front
  always_comb begin
    logic [spm_pkg::LenW:0] src;
    for (int i = 0; i < N; i++) begin
      src = (spm_pkg::LenW+1)'(i) + (spm_pkg::LenW+1)'(res_cnt);
      next_win[i] = (src < (spm_pkg::LenW+1)'(N)) ? appended[src[spm_pkg::CntW-1:0]]
                                                 : appended[i];
    end
  end

  // Pending count after the transfer
  always_comb begin
    priority if (!in_acc) begin
      cnt_d = cnt_q;
    end else if (flush || match_ok) begin
      cnt_d = '0;
    end else if (short_win) begin
      cnt_d = n_items[spm_pkg::CntW-1:0];
    end else begin
      cnt_d = spm_pkg::CntW'(eff_len - spm_pkg::LenW'(1));
    end
  end

  // Queue fill: load a fresh run or advance by one result
  always_comb begin
    slot_ctrl.load  = in_acc && (res_cnt != '0);
    slot_ctrl.shift = drain;
    priority if (slot_ctrl.load) begin
      oc_d = res_cnt;
    end else if (drain) begin
      oc_d = oc_q - spm_pkg::LenW'(1);
    end else begin
      oc_d = oc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      oc_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      oc_q  <= oc_d;
    end
  end

  // Row of window cells
  for (genvar g = 0; g < N; g++) begin : g_win
    spm_win_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (in_acc),
      .load_byte_i (next_win[g]),
      .cand_byte_i (cand_byte[g]),
      .pat_byte_i  (pattern_q[g*spm_pkg::ByteW +: spm_pkg::ByteW]),
      .byte_o      (win_byte[g]),
      .eq_o        (cell_eq[g])
    );
  end

  // Row of queue slots, head at place zero
  for (genvar g = 0; g < N; g++) begin : g_slot
    spm_pkg::byte_t nb;
    if (g == N - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_mid
      assign nb = slot_byte[g+1];
    end
    spm_slot_cell u_slot (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (slot_ctrl),
      .load_byte_i (res_byte[g]),
      .next_byte_i (nb),
      .byte_o      (slot_byte[g])
    );
  end

  // The queue holds one item's run at a time, so its last result closes it
  assign m_axis_tvalid = (oc_q != '0);
  assign m_axis_tdata  = slot_byte[0];
  assign m_axis_tlast  = (oc_q == spm_pkg::LenW'(1));

  `include "assert_macros.svh"

  `SPM_ASSERT(a_busy_blocks_input, (oc_q > spm_pkg::LenW'(1)) |-> !s_axis_tready, "input taken while a run is queued")
  `SPM_ASSERT(a_results_shown, (in_acc && (res_cnt != '0)) |=> m_axis_tvalid, "results of a transfer not presented")
  `SPM_ASSERT(a_flush_empties, (in_acc && flush) |=> (cnt_q == '0), "flush left bytes pending")
  `SPM_ASSERT(a_match_empties, (in_acc && match_take) |=> (cnt_q == '0) && (oc_q == $past(n_items)), "match run length wrong")
  `SPM_ASSERT_RST(a_reset_empty, !rst_ni |=> (oc_q == '0) && (cnt_q == '0), "reset left state behind")

endmodule

`default_nettype wire

// ===== rtl/spm_win_cell.sv =====
// ---------------------------------------------------------------------------
// spm_win_cell
// One place of the pending window: holds a byte and compares a candidate
// byte against its pattern byte.
// ---------------------------------------------------------------------------
`default_nettype none

module spm_win_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  spm_pkg::byte_t load_byte_i,
  input  spm_pkg::byte_t cand_byte_i,
  input  spm_pkg::byte_t pat_byte_i,
  output spm_pkg::byte_t byte_o,
  output logic          eq_o
);

  spm_pkg::byte_t byte_q, byte_d;

  // Hold unless the step logic writes a new window
  always_comb begin
    byte_d = load_i ? load_byte_i : byte_q;
  end

  // Payload only; the count in the top level says which places are live
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;
  assign eq_o   = (cand_byte_i == pat_byte_i);

endmodule

`default_nettype wire

// ===== rtl/spm_slot_cell.sv =====
// ---------------------------------------------------------------------------
// spm_slot_cell
// One place of the result queue: loads a result or takes the byte of its
// neighbour further from the head.
// ---------------------------------------------------------------------------
`default_nettype none

module spm_slot_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spm_pkg::slot_ctrl_t ctrl_i,
  input  spm_pkg::byte_t      load_byte_i,
  input  spm_pkg::byte_t      next_byte_i,
  output spm_pkg::byte_t      byte_o
);

  spm_pkg::byte_t byte_q, byte_d;

  // Load has priority over the shift towards the head
  always_comb begin
    priority if (ctrl_i.load) begin
      byte_d = load_byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = next_byte_i;
    end else begin
      byte_d = byte_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ===== tb/spm_mask_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spm_mask_checker
// Watches the input, output and configuration channels of the stream
// pattern masker, predicts the masked byte stream from the accepted input
// transfers and compares every output transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module spm_mask_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream as seen at the block
  input  logic                        in_tvalid_i,
  input  logic                        in_tready_i,
  input  logic [7:0]                  in_tdata_i,    // [7:0] data_byte
  input  logic                        in_tuser_i,    // [0] end_of_input
  // Output stream as seen at the block
  input  logic                        out_tvalid_i,
  input  logic                        out_tready_i,
  input  logic [7:0]                  out_tdata_i,   // [7:0] out_byte
  input  logic                        out_tlast_i,   // last_of_run
  // Configuration writes
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [spm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [spm_pkg::PatW-1:0]    cfg_data_i,
  // Status towards the testbench top
  output int unsigned                 errors_o,
  output int unsigned                 outstanding_o,
  output int unsigned                 checked_o
);

  typedef struct packed {
    spm_pkg::byte_t data;
    logic           last;
  } masked_byte_t;

  masked_byte_t                masked_q[$];
  logic [spm_pkg::PatW-1:0]    pattern_r = '0;
  logic [spm_pkg::CfgLenW-1:0] length_r  = spm_pkg::CfgLenW'(1);
  spm_pkg::byte_t              window_r [spm_pkg::MaxPattern];
  int unsigned                 held_r    = 0;
  int unsigned                 errors    = 0;
  int unsigned                 checked   = 0;

  // Remove the oldest held byte
  function automatic void drop_head();
    for (int i = 0; i + 1 < spm_pkg::MaxPattern; i++) window_r[i] = window_r[i + 1];
    held_r--;
  endfunction

  // Work out the bytes that one input transfer releases
  task automatic mask_step(spm_pkg::byte_t data, logic flush);
    spm_pkg::byte_t emitted[$];
    int unsigned    span;
    bit             hit;
    span = (length_r == 0) ? 1 :
           (length_r > spm_pkg::MaxPattern) ? spm_pkg::MaxPattern : length_r;
    if (flush) begin
      for (int i = 0; i < held_r; i++) emitted.push_back(window_r[i]);
      held_r = 0;
    end else begin
      window_r[held_r] = data;
      held_r++;
      // a shorter pattern than before: release the surplus first
      while (held_r > span) begin
        emitted.push_back(window_r[0]);
        drop_head();
      end
      if (held_r == span) begin
        hit = 1'b1;
        for (int i = 0; i < span; i++) begin
          if (window_r[i] != pattern_r[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          repeat (span) emitted.push_back(spm_pkg::StarByte);
          held_r = 0;
        end else begin
          emitted.push_back(window_r[0]);
          drop_head();
        end
      end
    end
    foreach (emitted[k]) begin
      masked_q.push_back('{data: emitted[k], last: (k == emitted.size() - 1)});
    end
  endtask

  // Compare, track configuration and predict, in that order, on each edge
  always @(posedge clk_i) begin : monitor
    masked_byte_t want;
    if (rst_ni) begin
      if (out_tvalid_i && out_tready_i) begin
        if (masked_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected output byte %02h last %0b with nothing pending",
                     $time, out_tdata_i, out_tlast_i);
          end
        end else begin
          want = masked_q.pop_front();
          checked++;
          if (out_tdata_i !== want.data || out_tlast_i !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: out_byte exp %02h got %02h, last_of_run exp %0b got %0b",
                       $time, want.data, out_tdata_i, want.last, out_tlast_i);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == spm_pkg::CfgPatternBytes) begin
          pattern_r = cfg_data_i;
        end else if (cfg_index_i == spm_pkg::CfgPatternLength) begin
          length_r = cfg_data_i[spm_pkg::CfgLenW-1:0];
        end
      end
      if (in_tvalid_i && in_tready_i) mask_step(in_tdata_i, in_tuser_i);
    end
    errors_o      <= errors;
    outstanding_o <= masked_q.size();
    checked_o     <= checked;
  end

endmodule

// ===== tb/tb_stream_pattern_masker_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stream_pattern_masker_unit
// Drives byte streams and pattern settings into the masker with random
// gaps and back-pressure; the checker beside the block predicts and
// compares every output transfer.
// ---------------------------------------------------------------------------
module tb_stream_pattern_masker_unit;

  localparam int unsigned TimeoutNs    = 3_000_000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhaseItems   = 23;
  // Register indexes that the block does not decode
  localparam logic [spm_pkg::CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [spm_pkg::CfgIdxW-1:0] CfgIdxSpareB = 2'd3;

  logic                        clk;
  logic                        rst_n     = 1'b0;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  logic [7:0]                  s_tdata   = '0;
  logic                        s_tuser   = 1'b0;
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic [7:0]                  m_tdata;
  logic                        m_tlast;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [spm_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [spm_pkg::PatW-1:0]    cfg_data  = '0;

  int unsigned        errors;
  int unsigned        outstanding;
  int unsigned        checked;

  // Shadow of the setting, used to build matching byte runs
  logic [spm_pkg::PatW-1:0] pat_shadow  = '0;
  int unsigned              span_shadow = 1;
  bit                       gapless     = 1'b0;
  bit                       stallfree   = 1'b0;
  int unsigned              items_sent  = 0;
  int unsigned              cfg_writes  = 0;

  stream_pattern_masker_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  spm_mask_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_tvalid_i   (s_tvalid),
    .in_tready_i   (s_tready),
    .in_tdata_i    (s_tdata),
    .in_tuser_i    (s_tuser),
    .out_tvalid_i  (m_tvalid),
    .out_tready_i  (m_tready),
    .out_tdata_i   (m_tdata),
    .out_tlast_i   (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #(TimeoutNs);
    $display("stream_pattern_masker_unit: mismatch");
    $finish;
  end

  // Output side: stall a random number of cycles before each transfer
  initial begin : sink
    int unsigned hold;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      hold = stallfree ? 0 : $urandom_range(0, 13);
      if (hold != 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(spm_pkg::byte_t data, logic flush);
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= data;
    s_tuser  <= flush;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    items_sent++;
  endtask

  // One register write; the caller lowers valid after its last write
  task automatic cfg_write(logic [spm_pkg::CfgIdxW-1:0] idx, logic [spm_pkg::PatW-1:0] value);
    logic [spm_pkg::CfgLenW-1:0] raw;
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_writes++;
    raw = value[spm_pkg::CfgLenW-1:0];
    if (idx == spm_pkg::CfgPatternBytes) begin
      pat_shadow = value;
    end else if (idx == spm_pkg::CfgPatternLength) begin
      span_shadow = (raw == 0) ? 1 :
                    (raw > spm_pkg::MaxPattern) ? spm_pkg::MaxPattern : raw;
    end
  endtask

  // Stop offering input and wait until every predicted byte has left
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Change the setting once the block has gone idle
  task automatic new_setting(bit wr_pat, logic [spm_pkg::PatW-1:0] pat,
                             bit wr_len, logic [spm_pkg::CfgLenW-1:0] len, bit wr_spare);
    bit len_first;
    len_first = $urandom_range(0, 1);
    drain();
    if (wr_spare) begin
      cfg_write($urandom_range(0, 1) ? CfgIdxSpareA : CfgIdxSpareB, {$urandom, $urandom});
    end
    if (wr_len && len_first) cfg_write(spm_pkg::CfgPatternLength, spm_pkg::PatW'(len));
    if (wr_pat) cfg_write(spm_pkg::CfgPatternBytes, pat);
    if (wr_len && !len_first) cfg_write(spm_pkg::CfgPatternLength, spm_pkg::PatW'(len));
    if (wr_pat || wr_len || wr_spare) cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-byte pattern of zero: zero is masked, all-ones passes
    new_setting(1'b1, '0, 1'b1, 4'd1, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);

    // Pattern "aba" with junk above the length: leftmost match, then flush
    new_setting(1'b1, 64'hF00D_C3A5_1E61_6261, 1'b1, 4'd3, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'($urandom), 1'b1);

    // Oversized length saturates to eight: full match, then a held prefix
    new_setting(1'b1, 64'h0123_4567_89AB_CDEF, 1'b1, 4'd15, 1'b0);
    for (int i = 0; i < spm_pkg::MaxPattern; i++) send_item(pat_shadow[8*i +: 8], 1'b0);
    for (int i = 0; i < 5; i++) send_item(pat_shadow[8*i +: 8], 1'b0);
    // Shrink the length while bytes are held
    new_setting(1'b0, '0, 1'b1, 4'd2, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'($urandom), 1'b1);

    // Zero length acts as one; spare index writes are ignored
    new_setting(1'b1, '1, 1'b1, 4'd0, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'($urandom), 1'b1);

    // Random settings, each followed by a mix of matches and noise
    for (int ph = 0; ph < RandPhases; ph++) begin
      logic [spm_pkg::PatW-1:0]    pat;
      logic [spm_pkg::CfgLenW-1:0] len;
      spm_pkg::byte_t              sym;
      bit                          wr_pat;
      bit                          wr_len;
      int unsigned                 start;
      int unsigned                 pick;
      int unsigned                 cut;
      int unsigned                 pos;
      if ($urandom_range(0, 3) == 0) begin
        // two-symbol pattern, so matches overlap in the stream
        sym = 8'($urandom);
        for (int i = 0; i < spm_pkg::MaxPattern; i++) begin
          pat[8*i +: 8] = sym ^ 8'($urandom_range(0, 1));
        end
      end else begin
        pat = {$urandom, $urandom};
      end
      if ($urandom_range(0, 9) < 7) len = 4'($urandom_range(1, spm_pkg::MaxPattern));
      else len = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(spm_pkg::MaxPattern + 1, 15));
      wr_pat = $urandom_range(0, 4) != 0;
      wr_len = $urandom_range(0, 4) != 0;
      if (!wr_pat && !wr_len) wr_len = 1'b1;
      new_setting(wr_pat, pat, wr_len, len, $urandom_range(0, 9) == 0);
      gapless   = $urandom_range(0, 3) == 0;
      stallfree = $urandom_range(0, 3) == 0;

      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          for (int i = 0; i < span_shadow; i++) send_item(pat_shadow[8*i +: 8], 1'b0);
        end else if (pick < 60) begin
          // broken match: a prefix then any byte
          cut = $urandom_range(0, span_shadow - 1);
          for (int i = 0; i < cut; i++) send_item(pat_shadow[8*i +: 8], 1'b0);
          send_item(8'($urandom), 1'b0);
        end else if (pick < 90) begin
          pos = $urandom_range(0, span_shadow - 1);
          send_item($urandom_range(0, 1) ? pat_shadow[8*pos +: 8] : 8'($urandom), 1'b0);
        end else begin
          send_item(8'($urandom), 1'b1);
        end
      end
    end

    drain();
    $display("Run covered %0d input items, %0d output bytes checked, %0d register writes.",
             items_sent, checked, cfg_writes);
    if (errors == 0) begin
      $display("stream_pattern_masker_unit: match");
    end else begin
      $display("stream_pattern_masker_unit: mismatch");
    end
    $finish;
  end

endmodule
